/* rtl/core/hff_pkg.sv */
// ---------------------------------------------------------------------------
// hff_pkg: shared types and constants of the hex field formatter
// Character codes, register indexes, length modes and the handshake between
// the sequencer and the nibble scanner.
// ---------------------------------------------------------------------------
package hff_pkg;

   localparam int NUM_NIBBLES = 16;
   localparam int NIB_CNT_W   = 5;

   // ASCII codes used in the formatted text.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NONE  = 8'h00;

   // Configuration register indexes.
   localparam logic [2:0] REG_FIELD_WIDTH  = 3'd0;
   localparam logic [2:0] REG_MIN_DIGITS   = 3'd1;
   localparam logic [2:0] REG_LEFT_JUSTIFY = 3'd2;
   localparam logic [2:0] REG_ZERO_PAD     = 3'd3;
   localparam logic [2:0] REG_ALT_PREFIX   = 3'd4;
   localparam logic [2:0] REG_UPPER_CASE   = 3'd5;
   localparam logic [2:0] REG_LENGTH_MODE  = 3'd6;

   // Operand length modes; every other code keeps all 64 bits.
   localparam logic [2:0] LEN_MODE_32 = 3'd0;
   localparam logic [2:0] LEN_MODE_16 = 3'd1;
   localparam logic [2:0] LEN_MODE_8  = 3'd2;

   typedef struct packed {
      logic                 start;
      logic [63:0]          value;    // operand aligned to the top nibble
      logic [NIB_CNT_W-1:0] nibbles;  // number of nibbles to examine
   } hff_scan_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [NIB_CNT_W-1:0] hex_len;  // significant hex digits, at least one
   } hff_scan_stat_type;

endpackage

/* rtl/core/hff_nibble_scan.sv */
// ---------------------------------------------------------------------------
// hff_nibble_scan: iterative significant-digit counter
// Shifts the operand left one nibble per cycle until a nonzero nibble is at
// the top or only one nibble is left, and reports the remaining count.
// ---------------------------------------------------------------------------
module hff_nibble_scan
   import hff_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  hff_scan_cmd_type  cmd,
   output hff_scan_stat_type stat
);

   logic [63:0]          scan_val_ff, scan_val_in;
   logic [NIB_CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic                 scan_busy_ff, scan_busy_in;
   logic                 found;

   assign found = (scan_val_ff[63:60] != 4'h0) || (scan_cnt_ff == NIB_CNT_W'(1));

   always_comb begin
      scan_val_in  = scan_val_ff;
      scan_cnt_in  = scan_cnt_ff;
      scan_busy_in = scan_busy_ff;
      if (cmd.start) begin
         scan_val_in  = cmd.value;
         scan_cnt_in  = cmd.nibbles;
         scan_busy_in = 1'b1;
      end else if (scan_busy_ff) begin
         if (found) begin
            scan_busy_in = 1'b0;
         end else begin
            scan_val_in = {scan_val_ff[59:0], 4'h0};
            scan_cnt_in = scan_cnt_ff - NIB_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_busy_ff <= 1'b0;
      end else begin
         scan_busy_ff <= scan_busy_in;
      end
      scan_val_ff <= scan_val_in;
      scan_cnt_ff <= scan_cnt_in;
   end

   assign stat.done    = scan_busy_ff && found;
   assign stat.hex_len = scan_cnt_ff;

endmodule

/* rtl/core/hff_char_gen.sv */
// ---------------------------------------------------------------------------
// hff_char_gen: character selection for one field position
// Maps a position of the field onto padding, prefix or digit and builds the
// ASCII code of that character.
// ---------------------------------------------------------------------------
module hff_char_gen
   import hff_pkg::*;
#(
   parameter int LEN_W = 7
) (
   input  logic [LEN_W-1:0] pos,
   input  logic [LEN_W-1:0] pad,
   input  logic [LEN_W-1:0] body_len,
   input  logic [LEN_W-1:0] prefix_len,
   input  logic [LEN_W-1:0] digits,
   input  logic             left_justify,
   input  logic             upper_case,
   input  logic [63:0]      value,
   output logic [7:0]       out_char
);

   logic [LEN_W-1:0] body_pos;
   logic [LEN_W-1:0] digit_idx;
   logic             in_body;
   logic [3:0]       nib;

   always_comb begin
      body_pos  = left_justify ? pos : pos - pad;
      in_body   = left_justify ? (pos < body_len) : (pos >= pad);
      digit_idx = digits - LEN_W'(1) - (body_pos - prefix_len);
      nib       = value[{digit_idx[3:0], 2'b00} +: 4];
      out_char  = CH_SPACE;
      if (in_body) begin
         if (body_pos < prefix_len) begin
            if (body_pos == '0) begin
               out_char = CH_ZERO;
            end else begin
               out_char = upper_case ? CH_X_UP : CH_X_LO;
            end
         end else if (digit_idx[LEN_W-1:4] != '0) begin
            // Leading zeros beyond the sixteen nibbles of the operand.
            out_char = CH_ZERO;
         end else if (nib < 4'd10) begin
            out_char = CH_ZERO + {4'h0, nib};
         end else begin
            out_char = (upper_case ? CH_A_UP : CH_A_LO) + {4'h0, nib} - 8'd10;
         end
      end
   end

endmodule

/* rtl/core/hex_field_formatter.sv */
// ---------------------------------------------------------------------------
// hex_field_formatter: printf-style hexadecimal field formatter
// Formats one unsigned value per request as hexadecimal text with width,
// precision, prefix, justification and case options, one character per
// result.
// ---------------------------------------------------------------------------
// Each request carries one 64-bit value, which is truncated to 32, 16 or 8 bits
// (or kept whole) by length_mode and then printed as hexadecimal text, one
// ASCII character per result, with rsp_tlast on the final character. The
// precision sets a minimum digit count, alt_prefix adds 0x (0X in upper case)
// to nonzero values, and spaces pad the field to field_width on the left, or
// on the right with left_justify. zero_pad without a precision or
// left_justify pads with zeros instead. A field with no characters at all
// yields a single result with rsp_tuser low, character 0 and rsp_tlast high.
// The digit scanner shifts one nibble per cycle, the sequencer then plans the
// layout in one state, and the emitter produces one character per cycle while
// the output register is free. req_tready is high only while the sequencer is
// idle, which it re-enters as soon as the final character is in the output
// register.
// Configuration writes are taken at any time but must only be issued while no
// request is in flight. MAX_FIELD bounds the field length; field_width and the
// digit count are capped to it.
// ---------------------------------------------------------------------------
module hex_field_formatter
   import hff_pkg::*;
#(
   parameter int MAX_FIELD = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] value
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tuser,   // [0] char_valid
   output logic        rsp_tlast,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data
);

   localparam int LEN_W = $clog2(MAX_FIELD + 1);
   // Signed width wide enough for every planning quantity.
   localparam int SW    = ((LEN_W > 7) ? LEN_W : 7) + 2;
   localparam logic signed [SW-1:0] MAX_S = SW'(MAX_FIELD);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_PLAN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [6:0] field_width_ff;
   logic [6:0] min_digits_ff;
   logic       left_justify_ff;
   logic       zero_pad_ff;
   logic       alt_prefix_ff;
   logic       upper_case_ff;
   logic [2:0] length_mode_ff;

   // Per-request state.
   logic [63:0]          held_value_ff, held_value_in;
   logic                 val_zero_ff, val_zero_in;
   logic [NIB_CNT_W-1:0] hex_len_ff, hex_len_in;
   logic [LEN_W-1:0]     digits_ff, digits_in;
   logic [LEN_W-1:0]     prefix_len_ff, prefix_len_in;
   logic [LEN_W-1:0]     body_len_ff, body_len_in;
   logic [LEN_W-1:0]     field_len_ff, field_len_in;
   logic [LEN_W-1:0]     pad_ff, pad_in;
   logic [LEN_W-1:0]     emit_pos_ff, emit_pos_in;

   // Output register.
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_tdata_ff, rsp_tdata_in;
   logic       rsp_tuser_ff, rsp_tuser_in;
   logic       rsp_tlast_ff, rsp_tlast_in;

   hff_scan_cmd_type  scan_cmd;
   hff_scan_stat_type scan_stat;

   logic       req_fire;
   logic       out_free;
   logic       emit_last;
   logic [7:0] gen_char;
   logic [63:0] trunc_value;

   // Planning terms.
   logic signed [SW-1:0] width_s, plen_s, prec_s, md_s, hexlen_s;
   logic signed [SW-1:0] dig_s, cap_s, blen_s, flen_s;
   logic                 zp_eff, no_digits;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff  <= 7'd0;
         min_digits_ff   <= 7'h7F;
         left_justify_ff <= 1'b0;
         zero_pad_ff     <= 1'b0;
         alt_prefix_ff   <= 1'b0;
         upper_case_ff   <= 1'b0;
         length_mode_ff  <= LEN_MODE_32;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FIELD_WIDTH:  field_width_ff  <= csr_data;
            REG_MIN_DIGITS:   min_digits_ff   <= csr_data;
            REG_LEFT_JUSTIFY: left_justify_ff <= csr_data[0];
            REG_ZERO_PAD:     zero_pad_ff     <= csr_data[0];
            REG_ALT_PREFIX:   alt_prefix_ff   <= csr_data[0];
            REG_UPPER_CASE:   upper_case_ff   <= csr_data[0];
            REG_LENGTH_MODE:  length_mode_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Truncate the operand and align it so that the scanner starts at the
   // most significant nibble that the length mode keeps.
   always_comb begin
      scan_cmd.start = req_fire;
      unique case (length_mode_ff)
         LEN_MODE_32: begin
            trunc_value      = {32'h0, req_tdata[31:0]};
            scan_cmd.value   = {req_tdata[31:0], 32'h0};
            scan_cmd.nibbles = NIB_CNT_W'(8);
         end
         LEN_MODE_16: begin
            trunc_value      = {48'h0, req_tdata[15:0]};
            scan_cmd.value   = {req_tdata[15:0], 48'h0};
            scan_cmd.nibbles = NIB_CNT_W'(4);
         end
         LEN_MODE_8: begin
            trunc_value      = {56'h0, req_tdata[7:0]};
            scan_cmd.value   = {req_tdata[7:0], 56'h0};
            scan_cmd.nibbles = NIB_CNT_W'(2);
         end
         default: begin
            trunc_value      = req_tdata;
            scan_cmd.value   = req_tdata;
            scan_cmd.nibbles = NIB_CNT_W'(NUM_NIBBLES);
         end
      endcase
   end

   hff_nibble_scan u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (scan_cmd),
      .stat  (scan_stat)
   );

   // Field layout. A negative precision means unspecified; zero padding then
   // turns the width minus the prefix into the precision. Zero printed with
   // an explicit precision of zero has neither digits nor prefix.
   always_comb begin
      width_s = $signed({{(SW-7){1'b0}}, field_width_ff});
      if (width_s > MAX_S) begin
         width_s = MAX_S;
      end
      md_s      = $signed({{(SW-7){min_digits_ff[6]}}, min_digits_ff});
      hexlen_s  = $signed({{(SW-NIB_CNT_W){1'b0}}, hex_len_ff});
      zp_eff    = zero_pad_ff && !left_justify_ff;
      no_digits = (min_digits_ff == 7'd0) && val_zero_ff;
      plen_s    = (alt_prefix_ff && !val_zero_ff) ? SW'(2) : SW'(0);
      if (!min_digits_ff[6]) begin
         prec_s = md_s;
      end else if (zp_eff) begin
         prec_s = width_s - plen_s;
      end else begin
         prec_s = -SW'(1);
      end
      dig_s = (prec_s > hexlen_s) ? prec_s : hexlen_s;
      cap_s = MAX_S - plen_s;
      if (dig_s > cap_s) begin
         dig_s = cap_s;
      end
      if (no_digits) begin
         dig_s  = SW'(0);
         plen_s = SW'(0);
      end
      blen_s = plen_s + dig_s;
      flen_s = (width_s > blen_s) ? width_s : blen_s;
   end

   hff_char_gen #(
      .LEN_W (LEN_W)
   ) u_char (
      .pos          (emit_pos_ff),
      .pad          (pad_ff),
      .body_len     (body_len_ff),
      .prefix_len   (prefix_len_ff),
      .digits       (digits_ff),
      .left_justify (left_justify_ff),
      .upper_case   (upper_case_ff),
      .value        (held_value_ff),
      .out_char     (gen_char)
   );

   // The empty field counts as a single final result.
   assign emit_last = (field_len_ff == '0) || (emit_pos_ff == field_len_ff - LEN_W'(1));

   // Sequencer: accept, scan digits, plan the layout, emit characters.
   always_comb begin
      state_in      = state_ff;
      held_value_in = held_value_ff;
      val_zero_in   = val_zero_ff;
      hex_len_in    = hex_len_ff;
      digits_in     = digits_ff;
      prefix_len_in = prefix_len_ff;
      body_len_in   = body_len_ff;
      field_len_in  = field_len_ff;
      pad_in        = pad_ff;
      emit_pos_in   = emit_pos_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               held_value_in = trunc_value;
               val_zero_in   = (trunc_value == 64'h0);
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_stat.done) begin
               hex_len_in = scan_stat.hex_len;
               state_in   = ST_PLAN;
            end
         end
         ST_PLAN: begin
            digits_in     = dig_s[LEN_W-1:0];
            prefix_len_in = plen_s[LEN_W-1:0];
            body_len_in   = blen_s[LEN_W-1:0];
            field_len_in  = flen_s[LEN_W-1:0];
            pad_in        = flen_s[LEN_W-1:0] - blen_s[LEN_W-1:0];
            emit_pos_in   = '0;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tlast_in  = emit_last;
               if (field_len_ff == '0) begin
                  rsp_tdata_in = CH_NONE;
                  rsp_tuser_in = 1'b0;
               end else begin
                  rsp_tdata_in = gen_char;
                  rsp_tuser_in = 1'b1;
               end
               emit_pos_in = emit_pos_ff + LEN_W'(1);
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         emit_pos_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         emit_pos_ff   <= emit_pos_in;
      end
      held_value_ff <= held_value_in;
      val_zero_ff   <= val_zero_in;
      hex_len_ff    <= hex_len_in;
      digits_ff     <= digits_in;
      prefix_len_ff <= prefix_len_in;
      body_len_ff   <= body_len_in;
      field_len_ff  <= field_len_in;
      pad_ff        <= pad_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tlast_ff  <= rsp_tlast_in;
   end

endmodule

/* test/tb_hex_field_formatter.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_hex_field_formatter: self-checking bench for the hex field formatter
// Each accepted request is formatted by a predictor in the bench and the
// resulting characters are queued. A checker compares every accepted result
// with the oldest queued character. Directed tests cover reset defaults and
// special cases. Random tests then run under four pacing phases.
// ---------------------------------------------------------------------------
module tb_hex_field_formatter;
   import hff_pkg::*;

   localparam int FIELD_CAP     = 64;
   localparam int SETTLE_CYCLES = 8;     // quiet cycles before a format change
   localparam int IDLE_LIMIT    = 5000;  // cycles with no handshake at all
   localparam int REPORT_LIMIT  = 10;

   // One character of a formatted field, as it should leave the result stream.
   typedef struct packed {
      logic [7:0] char_code;
      logic       char_valid;
      logic       last;
   } field_char_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;     // [63:0] value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] out_char
   logic        rsp_tuser;          // [0] char_valid
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [6:0]  csr_data   = '0;

   // Shadow copy of the format registers, starting at their reset values.
   logic [6:0]        fmt_width     = 7'd0;
   logic signed [6:0] fmt_precision = -7'sd1;
   logic              fmt_left      = 1'b0;
   logic              fmt_zero_pad  = 1'b0;
   logic              fmt_alt       = 1'b0;
   logic              fmt_upper     = 1'b0;
   logic [2:0]        fmt_len_mode  = LEN_MODE_32;

   // Characters predicted but not yet seen on the result stream.
   field_char_type pending_chars[$];

   int mismatch_count  = 0;
   int request_count   = 0;
   int char_count      = 0;
   int format_count    = 0;
   int sender_idle_pct = 0;
   int sink_stall_pct  = 0;
   int quiet_cycles    = 0;

   hex_field_formatter #(
      .MAX_FIELD(FIELD_CAP)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // The receiver stalls at random with the probability of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // Works out the characters of one formatted field from the shadow
   // registers and appends them to the queue of pending characters.
   function automatic void predict_field(input logic [63:0] raw);
      logic [63:0]    val;
      int             width, plen, prec, digits, blen, flen, pad, b, k, i, p;
      bit             zp, in_body;
      logic [3:0]     nib;
      field_char_type fc;
      val = raw;
      case (fmt_len_mode)
         LEN_MODE_32: val = {32'd0, raw[31:0]};
         LEN_MODE_16: val = {48'd0, raw[15:0]};
         LEN_MODE_8:  val = {56'd0, raw[7:0]};
         default:     val = raw;
      endcase
      width = (fmt_width > FIELD_CAP) ? FIELD_CAP : int'(fmt_width);
      zp    = fmt_zero_pad && !fmt_left;
      plen  = (fmt_alt && val != 0) ? 2 : 0;
      prec  = (fmt_precision < 0) ? -1 : int'(fmt_precision);
      // Zero padding without a precision turns into a precision that fills
      // the field once the prefix is accounted for.
      if (prec < 0 && zp) prec = width - plen;
      if (fmt_precision == 0 && val == 0) begin
         // An explicit precision of zero prints nothing for a zero value.
         digits = 0;
         plen   = 0;
      end else begin
         digits = 1;
         for (i = 1; i < 16; i++) begin
            if (val[4*i +: 4] != 4'd0) digits = i + 1;
         end
         if (prec > digits) digits = prec;
         if (digits > FIELD_CAP - plen) digits = FIELD_CAP - plen;
      end
      blen = plen + digits;
      flen = (width > blen) ? width : blen;
      pad  = flen - blen;
      if (flen == 0) begin
         // Nothing to print: a single marker with char_valid low.
         fc = '{char_code: CH_NONE, char_valid: 1'b0, last: 1'b1};
         pending_chars.push_back(fc);
         return;
      end
      for (p = 0; p < flen; p++) begin
         fc.char_code = CH_SPACE;
         b       = fmt_left ? p : p - pad;
         in_body = fmt_left ? (p < blen) : (p >= pad);
         if (in_body) begin
            if (b < plen) begin
               fc.char_code = (b == 0) ? CH_ZERO : (fmt_upper ? CH_X_UP : CH_X_LO);
            end else begin
               k = digits - 1 - (b - plen);
               if (k >= 16) begin
                  fc.char_code = CH_ZERO;
               end else begin
                  nib = val[4*k +: 4];
                  if (nib < 4'd10) fc.char_code = CH_ZERO + 8'(nib);
                  else fc.char_code = (fmt_upper ? CH_A_UP : CH_A_LO) + 8'(nib) - 8'd10;
               end
            end
         end
         fc.char_valid = 1'b1;
         fc.last       = (p + 1 == flen);
         pending_chars.push_back(fc);
      end
   endfunction

   // Result checker: every accepted character is matched against the oldest
   // pending one. A character that arrives with nothing pending is an error.
   always @(posedge clock) begin : check_chars
      field_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         char_count++;
         if (pending_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("ERROR: unexpected result char=%h valid=%b last=%b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata !== want.char_code || rsp_tuser !== want.char_valid ||
                rsp_tlast !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("ERROR: expected char=%h valid=%b last=%b, got %h %b %b",
                           want.char_code, want.char_valid, want.last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // Watchdog: any accepted request, result or register write clears it.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("ERROR: no progress for %0d cycles, %0d characters pending",
                  IDLE_LIMIT, pending_chars.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one register write and holds it until taken. The write strobe is
   // left high so that back-to-back writes do not toggle it within one step.
   task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_FIELD_WIDTH:  fmt_width     = data;
         REG_MIN_DIGITS:   fmt_precision = data;
         REG_LEFT_JUSTIFY: fmt_left      = data[0];
         REG_ZERO_PAD:     fmt_zero_pad  = data[0];
         REG_ALT_PREFIX:   fmt_alt       = data[0];
         REG_UPPER_CASE:   fmt_upper     = data[0];
         REG_LENGTH_MODE:  fmt_len_mode  = data[2:0];
         default: ;
      endcase
   endtask

   // Loads a complete format setting. Only called while nothing is in flight.
   task automatic configure(input logic [6:0] width, input logic [6:0] precision,
                            input logic left, input logic zero_pad,
                            input logic alt, input logic upper,
                            input logic [2:0] len_mode);
      write_reg(REG_FIELD_WIDTH, width);
      write_reg(REG_MIN_DIGITS, precision);
      write_reg(REG_LEFT_JUSTIFY, {6'd0, left});
      write_reg(REG_ZERO_PAD, {6'd0, zero_pad});
      write_reg(REG_ALT_PREFIX, {6'd0, alt});
      write_reg(REG_UPPER_CASE, {6'd0, upper});
      write_reg(REG_LENGTH_MODE, {4'd0, len_mode});
      csr_valid <= 1'b0;
      format_count++;
   endtask

   // Sends one value, with a random idle gap ahead of it in the sender idle
   // phases. Valid stays high after acceptance so that the next request is
   // offered without a gap.
   task automatic send_value(input logic [63:0] value);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_field(value);
      request_count++;
   endtask

   // Holds the sender back until every pending character has arrived, then
   // lets the block settle before anything else happens.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      case ($urandom_range(6))
         0:       v = 64'd0;
         1:       v = {$urandom, $urandom} >> $urandom_range(63);
         2:       v = 64'd1 << $urandom_range(63);
         3:       v = ~64'd0 >> $urandom_range(63);
         4:       v = 64'($urandom_range(255));
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Random format setting, mostly small fields with the occasional
   // oversize width or precision.
   task automatic configure_random();
      logic [6:0] width, precision;
      case ($urandom_range(9))
         0:       width = 7'($urandom_range(64, 127));
         default: width = 7'($urandom_range(0, 20));
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3: precision = 7'h7F;
         4:          precision = 7'($urandom_range(64, 126));
         5:          precision = 7'($urandom_range(40, 63));
         default:    precision = 7'($urandom_range(0, 12));
      endcase
      configure(width, precision, 1'($urandom), 1'($urandom), 1'($urandom),
                1'($urandom), 3'($urandom_range(7)));
   endtask

   // With reset values in place the block prints plain 32-bit lower-case hex.
   task automatic test_reset_defaults();
      send_value(64'd0);
      send_value(~64'd0);
      send_value(64'h0123_4567_89AB_CDEF);
      wait_idle();
   endtask

   // Directed format cases: empty fields, zero padding, every length mode,
   // justification, case and fields at or beyond the size limit.
   task automatic test_special_cases();
      // Precision zero with a zero value leaves the field empty.
      configure(7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0, LEN_MODE_32);
      send_value(64'd0);
      send_value(64'h5);
      wait_idle();
      // Same case inside a left-justified field: only spaces, no prefix.
      configure(7'd6, 7'd0, 1'b1, 1'b0, 1'b1, 1'b0, LEN_MODE_32);
      send_value(64'd0);
      wait_idle();
      // Zero padding derives the precision from width minus the prefix.
      configure(7'd10, 7'h7F, 1'b0, 1'b1, 1'b1, 1'b0, LEN_MODE_32);
      send_value(64'hAB);
      send_value(64'd0);
      wait_idle();
      // The most negative precision; left justify overrides zero padding.
      configure(7'd10, 7'h40, 1'b1, 1'b1, 1'b1, 1'b1, LEN_MODE_16);
      send_value(64'hFFFF_FFFF_FFFF_BEEF);
      wait_idle();
      // The undefined length codes keep all 64 bits.
      configure(7'd0, 7'h7F, 1'b0, 1'b0, 1'b1, 1'b1, 3'd7);
      send_value(~64'd0);
      send_value(64'h8000_0000_0000_0000);
      wait_idle();
      configure(7'd8, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1, 3'd6);
      send_value(64'hDEAD_0000_0000_0000);
      wait_idle();
      // Oversize width and a precision near the cap, with and without prefix.
      configure(7'd127, 7'd62, 1'b0, 1'b0, 1'b1, 1'b0, 3'd3);
      send_value(64'd1);
      send_value(64'd0);
      wait_idle();
      configure(7'd127, 7'd63, 1'b0, 1'b1, 1'b0, 1'b0, 3'd4);
      send_value(64'hFEDC_BA98_7654_3210);
      wait_idle();
      configure(7'd127, 7'h7F, 1'b0, 1'b1, 1'b1, 1'b0, 3'd5);
      send_value(~64'd0);
      send_value(64'd0);
      wait_idle();
      // Full-width field, left justified, with 8-bit truncation.
      configure(7'd64, 7'd20, 1'b1, 1'b0, 1'b0, 1'b1, LEN_MODE_8);
      send_value(64'h1FF);
      wait_idle();
      // Truncation to zero drops the prefix; precision one still shows a digit.
      configure(7'd3, 7'd1, 1'b0, 1'b0, 1'b1, 1'b0, LEN_MODE_8);
      send_value(64'h100);
      send_value(64'h7A);
      wait_idle();
      configure(7'd2, 7'd2, 1'b0, 1'b0, 1'b1, 1'b1, LEN_MODE_16);
      send_value(64'd0);
      send_value(64'h1_0000_ABCD);
      wait_idle();
   endtask

   // Random settings and values under one pacing of sender and receiver.
   task automatic test_random_phase(input int idle_pct, input int stall_pct);
      int s, n;
      sender_idle_pct = idle_pct;
      sink_stall_pct  = stall_pct;
      for (s = 0; s < 6; s++) begin
         configure_random();
         for (n = 0; n < 8; n++) send_value(random_value());
         wait_idle();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_special_cases();
      test_random_phase(0, 0);
      test_random_phase(67, 0);
      test_random_phase(0, 67);
      test_random_phase(7, 7);

      wait_idle();
      if (pending_chars.size() != 0) mismatch_count++;
      $display("Formatted %0d values into %0d characters under %0d format settings,",
               request_count, char_count, format_count);
      $display("with free-running, sender-idle, receiver-stall and mixed pacing.");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
